### hdl/sqbs_pkg.sv
// ----------------------------------------------------------------------------
// sqbs_pkg: shared types and constants
// Codes, queue job format and fixed-point constants of the sprite quad setup.
// ----------------------------------------------------------------------------
package sqbs_pkg;

  localparam int SLOTS     = 32;
  localparam int SLOT_W    = $clog2(SLOTS);
  localparam int CNT_W     = $clog2(SLOTS + 1);
  localparam int Q_DEPTH   = 2;
  localparam int Q_PTR_W   = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int CFG_IDX_W = 2;
  localparam int OUT_SLOT_W = 5;

  localparam logic [1:0] FUNC_PLAIN = 2'd0;
  localparam logic [1:0] FUNC_TEX   = 2'd1;
  localparam logic [1:0] FUNC_FLUSH = 2'd2;
  localparam logic [1:0] FUNC_NONE  = 2'd3;

  localparam logic [1:0] KIND_VERTEX = 2'd0;
  localparam logic [1:0] KIND_BIND   = 2'd1;
  localparam logic [1:0] KIND_DRAW   = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_WHITE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAXQ  = 2'd1;

  localparam logic [16:0] ONE_Q16 = 17'd65536;
  localparam logic signed [31:0] COEF_A = 32'sd102944;
  localparam logic signed [31:0] COEF_B = 32'sd42048;
  localparam logic signed [31:0] COEF_C = 32'sd4640;
  localparam logic [15:0] QUARTER_TURN = 16'd16384;

  typedef enum logic [1:0] {JOB_BIND, JOB_DRAW, JOB_QUAD} job_kind_t;

  typedef struct packed {
    job_kind_t          kind;
    logic [SLOT_W-1:0]  slot;
    logic [31:0]        handle;
    logic [18:0]        count;
    logic               last;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic [30:0]        size_x;
    logic [30:0]        size_y;
    logic [15:0]        angle;
    logic [16:0]        u0;
    logic [16:0]        u1;
    logic [16:0]        v0;
    logic [16:0]        v1;
  } job_t;

  typedef struct packed {
    logic [31:0] white_texture;
    logic [15:0] max_quads;
  } cfg_t;

  typedef struct packed {
    logic push;
    logic full;
    logic pop;
    logic empty;
  } q_ctl_t;

endpackage

### hdl/sqbs_ram.sv
// ----------------------------------------------------------------------------
// sqbs_ram: generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module sqbs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hdl/sqbs_queue.sv
// ----------------------------------------------------------------------------
// sqbs_queue: job queue
// Short FIFO of jobs between the front and the back.
// ----------------------------------------------------------------------------
module sqbs_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  sqbs_pkg::job_t push_data,
  output logic          full,
  input  logic          pop,
  output logic          empty,
  output sqbs_pkg::job_t head
);
  import sqbs_pkg::*;

  job_t               ent_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_r, rd_r;
  logic [Q_PTR_W:0]   cnt_r;

  function automatic logic [Q_PTR_W-1:0] inc(input logic [Q_PTR_W-1:0] p);
    if (p == Q_PTR_W'(Q_DEPTH - 1)) begin
      return '0;
    end
    return p + 1'b1;
  endfunction

  assign full  = (cnt_r == (Q_PTR_W+1)'(Q_DEPTH));
  assign empty = (cnt_r == '0);
  assign head  = ent_r[rd_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wr_r <= inc(wr_r);
      end
      if (pop) begin
        rd_r <= inc(rd_r);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
    if (push) begin
      ent_r[wr_r] <= push_data;
    end
  end

endmodule

### hdl/sqbs_front.sv
// ----------------------------------------------------------------------------
// sqbs_front: request front end
// Accepts requests, owns the slot table and batch counters, queues jobs.
// ----------------------------------------------------------------------------
module sqbs_front (
  input  logic               clk,
  input  logic               rst_n,
  input  sqbs_pkg::cfg_t     cfg,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_func,
  input  logic [31:0]        in_texture_handle,
  input  logic signed [31:0] in_pos_x,
  input  logic signed [31:0] in_pos_y,
  input  logic [30:0]        in_size_x,
  input  logic [30:0]        in_size_y,
  input  logic [15:0]        in_angle,
  input  logic [16:0]        in_ul_u,
  input  logic [16:0]        in_ul_v,
  input  logic [16:0]        in_br_u,
  input  logic [16:0]        in_br_v,
  output logic               q_push,
  output sqbs_pkg::job_t     q_data,
  input  logic               q_full
);
  import sqbs_pkg::*;

  typedef enum logic [2:0] {F_IDLE, F_BRD, F_BPUSH, F_DRAW, F_SRD, F_SCMP, F_QUAD} state_t;

  state_t             state_r;
  logic [1:0]         func_r;
  logic [31:0]        handle_r;
  logic signed [31:0] pos_x_r, pos_y_r;
  logic [30:0]        size_x_r, size_y_r;
  logic [15:0]        angle_r;
  logic [16:0]        u0_r, u1_r, v0_r, v1_r;
  logic [CNT_W-1:0]   idx_r, next_slot_r;
  logic [SLOT_W-1:0]  slot_r;
  logic [15:0]        qcount_r;
  logic [31:0]        rdata;
  logic               ram_we;
  logic               accept;
  logic               need_flush;

  function automatic logic [16:0] cap(input logic [16:0] v);
    return (v > ONE_Q16) ? ONE_Q16 : v;
  endfunction

  sqbs_ram #(.WIDTH(32), .DEPTH(SLOTS)) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (next_slot_r[SLOT_W-1:0]),
    .wdata (handle_r),
    .raddr (idx_r[SLOT_W-1:0]),
    .rdata (rdata)
  );

  assign in_stall   = (state_r != F_IDLE);
  assign accept     = in_valid && !in_stall;
  assign need_flush = (qcount_r >= cfg.max_quads) ||
                      ((in_func == FUNC_TEX) && (next_slot_r >= CNT_W'(SLOTS)));
  assign ram_we     = (state_r == F_SRD) && (idx_r >= next_slot_r);

  always_comb begin
    q_push        = 1'b0;
    q_data        = '0;
    q_data.pos_x  = pos_x_r;
    q_data.pos_y  = pos_y_r;
    q_data.size_x = size_x_r;
    q_data.size_y = size_y_r;
    q_data.angle  = angle_r;
    q_data.u0     = u0_r;
    q_data.u1     = u1_r;
    q_data.v0     = v0_r;
    q_data.v1     = v1_r;
    case (state_r)
      F_BPUSH: begin
        q_push        = !q_full;
        q_data.kind   = JOB_BIND;
        q_data.slot   = idx_r[SLOT_W-1:0];
        q_data.handle = (idx_r == '0) ? cfg.white_texture : rdata;
      end
      F_DRAW: begin
        q_push       = !q_full;
        q_data.kind  = JOB_DRAW;
        q_data.count = 19'({qcount_r, 2'b00}) + 19'({qcount_r, 1'b0});
        q_data.last  = (func_r == FUNC_FLUSH);
      end
      F_QUAD: begin
        q_push      = !q_full;
        q_data.kind = JOB_QUAD;
        q_data.slot = slot_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= F_IDLE;
      next_slot_r <= CNT_W'(1);
      qcount_r    <= '0;
      idx_r       <= '0;
    end else begin
      case (state_r)
        F_IDLE: begin
          if (accept && in_func != FUNC_NONE) begin
            if (in_func == FUNC_FLUSH || need_flush) begin
              idx_r   <= '0;
              state_r <= F_BRD;
            end else if (in_func == FUNC_TEX) begin
              idx_r   <= CNT_W'(1);
              state_r <= F_SRD;
            end else begin
              state_r <= F_QUAD;
            end
          end
        end
        F_BRD: state_r <= F_BPUSH;
        F_BPUSH: begin
          if (!q_full) begin
            idx_r   <= idx_r + 1'b1;
            state_r <= (idx_r + 1'b1 >= next_slot_r) ? F_DRAW : F_BRD;
          end
        end
        F_DRAW: begin
          if (!q_full) begin
            qcount_r    <= '0;
            next_slot_r <= CNT_W'(1);
            idx_r       <= CNT_W'(1);
            case (func_r)
              FUNC_FLUSH: state_r <= F_IDLE;
              FUNC_TEX:   state_r <= F_SRD;
              default:    state_r <= F_QUAD;
            endcase
          end
        end
        F_SRD: begin
          if (idx_r >= next_slot_r) begin
            // not in table: take the next free slot
            next_slot_r <= next_slot_r + 1'b1;
            state_r     <= F_QUAD;
          end else begin
            state_r <= F_SCMP;
          end
        end
        F_SCMP: begin
          if (rdata == handle_r) begin
            state_r <= F_QUAD;
          end else begin
            idx_r   <= idx_r + 1'b1;
            state_r <= F_SRD;
          end
        end
        F_QUAD: begin
          if (!q_full) begin
            qcount_r <= qcount_r + 1'b1;
            state_r  <= F_IDLE;
          end
        end
        default: state_r <= F_IDLE;
      endcase
    end
    // payload
    if (accept) begin
      func_r   <= in_func;
      handle_r <= in_texture_handle;
      pos_x_r  <= in_pos_x;
      pos_y_r  <= in_pos_y;
      size_x_r <= in_size_x;
      size_y_r <= in_size_y;
      angle_r  <= in_angle;
      slot_r   <= '0;
      if (in_func == FUNC_TEX) begin
        u0_r <= cap(in_ul_u);
        u1_r <= cap(in_br_u);
        v0_r <= cap(in_br_v);
        v1_r <= cap(in_ul_v);
      end else begin
        u0_r <= '0;
        u1_r <= ONE_Q16;
        v0_r <= '0;
        v1_r <= ONE_Q16;
      end
    end else if (state_r == F_SRD && idx_r >= next_slot_r) begin
      slot_r <= next_slot_r[SLOT_W-1:0];
    end else if (state_r == F_SCMP && rdata == handle_r) begin
      slot_r <= idx_r[SLOT_W-1:0];
    end
  end

endmodule

### hdl/sqbs_back.sv
// ----------------------------------------------------------------------------
// sqbs_back: job execution
// Trig, corner rotation and result output over one shared multiplier.
// ----------------------------------------------------------------------------
module sqbs_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_empty,
  input  sqbs_pkg::job_t     q_head,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_kind,
  output logic signed [31:0] out_vertex_x,
  output logic signed [31:0] out_vertex_y,
  output logic [16:0]        out_tex_u,
  output logic [16:0]        out_tex_v,
  output logic [4:0]         out_slot,
  output logic [31:0]        out_bound_texture,
  output logic [18:0]        out_index_count,
  output logic               out_last
);
  import sqbs_pkg::*;

  typedef enum logic [3:0] {
    B_IDLE, B_X2, B_X3, B_X5, B_AX, B_CX, B_BX, B_SUM,
    B_P1, B_P2, B_P3, B_P4, B_P5, B_VA, B_VB
  } state_t;

  localparam logic signed [51:0] SAT_MAX = 52'sd2147483647;
  localparam logic signed [51:0] SAT_MIN = -52'sd2147483648;

  state_t             state_r;
  job_t               job_r;
  logic               out_valid_r;
  logic [15:0]        phase_r;
  logic               pass_r;
  logic [16:0]        x2_r, x3_r, x5_r;
  logic signed [49:0] acc_r, p_r;
  logic signed [17:0] sin_r, cos_r;
  logic signed [49:0] pxc_r, pys_r, pxs_r, pyc_r;
  logic signed [51:0] tx_r, ty_r;
  logic [1:0]         corner_r;

  logic signed [31:0] mul_a;
  logic signed [17:0] mul_b;
  logic [15:0]        frac;
  logic [16:0]        x;
  logic signed [49:0] sum, sh;
  logic [16:0]        mag;
  logic signed [17:0] trig;
  logic               out_free;
  logic               xneg, yneg;
  logic signed [51:0] rx, ry, vx, vy;

  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;

  // quarter-wave argument, mirrored in odd quadrants
  assign frac = {phase_r[13:0], 2'b00};
  assign x    = phase_r[14] ? (ONE_Q16 - {1'b0, frac}) : {1'b0, frac};
  assign sum  = acc_r - p_r;
  assign sh   = sum >>> 16;
  assign mag  = (sh > 50'sd65536) ? ONE_Q16 : sh[16:0];
  assign trig = phase_r[15] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});

  assign xneg = (corner_r == 2'd0) || (corner_r == 2'd3);
  assign yneg = !corner_r[1];
  assign rx   = (tx_r + 52'sd65536) >>> 17;
  assign ry   = (ty_r + 52'sd65536) >>> 17;
  assign vx   = rx + 52'(job_r.pos_x);
  assign vy   = ry + 52'(job_r.pos_y);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      B_X2: begin mul_a = 32'({15'd0, x});               mul_b = {1'b0, x};    end
      B_X3: begin mul_a = 32'({15'd0, p_r[32:16]});      mul_b = {1'b0, x};    end
      B_X5: begin mul_a = 32'({15'd0, p_r[32:16]});      mul_b = {1'b0, x2_r}; end
      B_AX: begin mul_a = COEF_A;                        mul_b = {1'b0, x};    end
      B_CX: begin mul_a = COEF_C;                        mul_b = {1'b0, x5_r}; end
      B_BX: begin mul_a = COEF_B;                        mul_b = {1'b0, x3_r}; end
      B_P1: begin mul_a = $signed({1'b0, job_r.size_x}); mul_b = cos_r;        end
      B_P2: begin mul_a = $signed({1'b0, job_r.size_y}); mul_b = sin_r;        end
      B_P3: begin mul_a = $signed({1'b0, job_r.size_x}); mul_b = sin_r;        end
      B_P4: begin mul_a = $signed({1'b0, job_r.size_y}); mul_b = cos_r;        end
      default: ;
    endcase
  end

  assign q_pop = (state_r == B_IDLE) && !q_empty &&
                 ((q_head.kind == JOB_QUAD) || out_free);

  always_ff @(posedge clk) begin
    p_r <= mul_a * mul_b;
    if (!rst_n) begin
      state_r     <= B_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        B_IDLE: begin
          if (q_pop) begin
            job_r <= q_head;
            if (q_head.kind == JOB_QUAD) begin
              phase_r <= q_head.angle;
              pass_r  <= 1'b0;
              state_r <= B_X2;
            end else begin
              out_valid_r       <= 1'b1;
              out_kind          <= (q_head.kind == JOB_BIND) ? KIND_BIND : KIND_DRAW;
              out_vertex_x      <= '0;
              out_vertex_y      <= '0;
              out_tex_u         <= '0;
              out_tex_v         <= '0;
              out_slot          <= (q_head.kind == JOB_BIND) ?
                                   OUT_SLOT_W'(q_head.slot) : '0;
              out_bound_texture <= (q_head.kind == JOB_BIND) ? q_head.handle : '0;
              out_index_count   <= (q_head.kind == JOB_DRAW) ? q_head.count : '0;
              out_last          <= (q_head.kind == JOB_DRAW) && q_head.last;
            end
          end
        end
        B_X2: state_r <= B_X3;
        B_X3: begin x2_r <= p_r[32:16]; state_r <= B_X5; end
        B_X5: begin x3_r <= p_r[32:16]; state_r <= B_AX; end
        B_AX: begin x5_r <= p_r[32:16]; state_r <= B_CX; end
        B_CX: begin acc_r <= p_r; state_r <= B_BX; end
        B_BX: begin acc_r <= acc_r + p_r; state_r <= B_SUM; end
        B_SUM: begin
          if (!pass_r) begin
            sin_r   <= trig;
            phase_r <= phase_r + QUARTER_TURN;
            pass_r  <= 1'b1;
            state_r <= B_X2;
          end else begin
            cos_r   <= trig;
            state_r <= B_P1;
          end
        end
        B_P1: state_r <= B_P2;
        B_P2: begin pxc_r <= p_r; state_r <= B_P3; end
        B_P3: begin pys_r <= p_r; state_r <= B_P4; end
        B_P4: begin pxs_r <= p_r; state_r <= B_P5; end
        B_P5: begin pyc_r <= p_r; corner_r <= 2'd0; state_r <= B_VA; end
        B_VA: begin
          tx_r    <= (xneg ? -52'(pxc_r) : 52'(pxc_r)) - (yneg ? -52'(pys_r) : 52'(pys_r));
          ty_r    <= (xneg ? -52'(pxs_r) : 52'(pxs_r)) + (yneg ? -52'(pyc_r) : 52'(pyc_r));
          state_r <= B_VB;
        end
        B_VB: begin
          if (out_free) begin
            out_valid_r       <= 1'b1;
            out_kind          <= KIND_VERTEX;
            out_vertex_x      <= (vx > SAT_MAX) ? 32'sh7FFFFFFF :
                                 (vx < SAT_MIN) ? 32'sh80000000 : vx[31:0];
            out_vertex_y      <= (vy > SAT_MAX) ? 32'sh7FFFFFFF :
                                 (vy < SAT_MIN) ? 32'sh80000000 : vy[31:0];
            out_tex_u         <= (corner_r == 2'd1 || corner_r == 2'd2) ? job_r.u1 : job_r.u0;
            out_tex_v         <= corner_r[1] ? job_r.v1 : job_r.v0;
            out_slot          <= OUT_SLOT_W'(job_r.slot);
            out_bound_texture <= '0;
            out_index_count   <= '0;
            out_last          <= (corner_r == 2'd3);
            corner_r          <= corner_r + 1'b1;
            state_r           <= (corner_r == 2'd3) ? B_IDLE : B_VA;
          end
        end
        default: state_r <= B_IDLE;
      endcase
    end
  end

endmodule

### hdl/sprite_quad_batch_setup.sv
// ----------------------------------------------------------------------------
// sprite_quad_batch_setup: batched sprite quad vertex generation
// Turns sprite requests into vertices, slot bindings and draw commands.
// ----------------------------------------------------------------------------
// A request is taken when in_valid is high and in_stall low. A quad gives four
// vertex beats, a flush gives one binding beat per slot in use and a draw
// beat; out_last marks the final beat of a request. The back end runs every
// quad through one shared 32x18 multiplier: two polynomial passes for sin and
// cos (B_X2 to B_SUM), corner products (B_P1 to B_P5), then B_VA and B_VB per
// vertex, B_VB waiting while the output stalls. Bindings and draws go out from
// the back end's idle state. The front end reads the slot table one entry at a
// time (read and compare per slot searched, read and push per slot bound) and
// runs ahead of the back end through a two-entry job queue. Configuration
// writes complete at once (cfg_ready is tied high) and are only legal while the block is idle.
module sprite_quad_batch_setup (
  input  logic                           clk,
  input  logic                           rst_n,
  // configuration
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [sqbs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                    cfg_wdata,
  // request beats
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [1:0]                     in_func,
  input  logic [31:0]                    in_texture_handle,
  input  logic signed [31:0]             in_pos_x,
  input  logic signed [31:0]             in_pos_y,
  input  logic [30:0]                    in_size_x,
  input  logic [30:0]                    in_size_y,
  input  logic [15:0]                    in_angle,
  input  logic [16:0]                    in_ul_u,
  input  logic [16:0]                    in_ul_v,
  input  logic [16:0]                    in_br_u,
  input  logic [16:0]                    in_br_v,
  // result beats
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [1:0]                     out_kind,
  output logic signed [31:0]             out_vertex_x,
  output logic signed [31:0]             out_vertex_y,
  output logic [16:0]                    out_tex_u,
  output logic [16:0]                    out_tex_v,
  output logic [4:0]                     out_slot,
  output logic [31:0]                    out_bound_texture,
  output logic [18:0]                    out_index_count,
  output logic                           out_last
);
  import sqbs_pkg::*;

  cfg_t   cfg_r;
  q_ctl_t qc;
  job_t   q_data, q_head;

  // registers are written on a single beat; unknown indexes are dropped
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.white_texture <= '0;
      cfg_r.max_quads     <= 16'd1000;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_WHITE: cfg_r.white_texture <= cfg_wdata;
        CFG_MAXQ:  cfg_r.max_quads     <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  // front: classify, slot lookup, flush sequencing
  sqbs_front u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg               (cfg_r),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_func           (in_func),
    .in_texture_handle (in_texture_handle),
    .in_pos_x          (in_pos_x),
    .in_pos_y          (in_pos_y),
    .in_size_x         (in_size_x),
    .in_size_y         (in_size_y),
    .in_angle          (in_angle),
    .in_ul_u           (in_ul_u),
    .in_ul_v           (in_ul_v),
    .in_br_u           (in_br_u),
    .in_br_v           (in_br_v),
    .q_push            (qc.push),
    .q_data            (q_data),
    .q_full            (qc.full)
  );

  sqbs_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (qc.push),
    .push_data (q_data),
    .full      (qc.full),
    .pop       (qc.pop),
    .empty     (qc.empty),
    .head      (q_head)
  );

  // back: trig, vertex math, output register
  sqbs_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_empty           (qc.empty),
    .q_head            (q_head),
    .q_pop             (qc.pop),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_kind          (out_kind),
    .out_vertex_x      (out_vertex_x),
    .out_vertex_y      (out_vertex_y),
    .out_tex_u         (out_tex_u),
    .out_tex_v         (out_tex_v),
    .out_slot          (out_slot),
    .out_bound_texture (out_bound_texture),
    .out_index_count   (out_index_count),
    .out_last          (out_last)
  );

  // queue is never written while full
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(qc.push && qc.full))
    else $error("job queue overflow");

  // back end only pops a job that is there
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    qc.pop |-> !qc.empty)
    else $error("job queue underflow");

  // a request is only taken once the previous one is fully queued
  a_front_busy: assert property (@(posedge clk) disable iff (!rst_n)
    qc.push |-> in_stall)
    else $error("job queued while front idle");

endmodule

### tb/sprite_quad_batch_setup_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sprite_quad_batch_setup_test: self-checking bench for the sprite quad setup
// Drives directed and random sprite requests in bursts with random gaps,
// predicts every vertex, slot binding and draw beat, and compares each result
// beat field by field while the output side stalls on its own pattern. The
// configuration changes between phases, only once the block has drained.
// ----------------------------------------------------------------------------
module sprite_quad_batch_setup_test;
  import sqbs_pkg::*;

  // ---- request and result beat formats -------------------------------------
  typedef struct {
    logic [1:0]         func;
    logic [31:0]        handle;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic [30:0]        size_x;
    logic [30:0]        size_y;
    logic [15:0]        angle;
    logic [16:0]        ul_u;
    logic [16:0]        ul_v;
    logic [16:0]        br_u;
    logic [16:0]        br_v;
  } sprite_req_t;

  typedef struct {
    logic [1:0]  kind;
    logic [31:0] vx;
    logic [31:0] vy;
    logic [16:0] tu;
    logic [16:0] tv;
    logic [4:0]  slot;
    logic [31:0] bound;
    logic [18:0] count;
    logic        last;
  } gfx_beat_t;

  localparam int IDLE_PAUSE = 100;   // covers a request that gives no beat
  localparam int WATCHDOG   = 4000;  // cycles without any accepted beat

  // corner order: upper left, upper right, lower right, lower left
  localparam int CORNER_SX [4] = '{-1, 1, 1, -1};
  localparam int CORNER_SY [4] = '{-1, -1, 1, 1};

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_WHITE;
  logic [31:0]          cfg_wdata = '0;

  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [1:0]         in_func = FUNC_PLAIN;
  logic [31:0]        in_texture_handle = '0;
  logic signed [31:0] in_pos_x = '0;
  logic signed [31:0] in_pos_y = '0;
  logic [30:0]        in_size_x = '0;
  logic [30:0]        in_size_y = '0;
  logic [15:0]        in_angle = '0;
  logic [16:0]        in_ul_u = '0;
  logic [16:0]        in_ul_v = '0;
  logic [16:0]        in_br_u = '0;
  logic [16:0]        in_br_v = '0;

  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [1:0]         out_kind;
  logic signed [31:0] out_vertex_x;
  logic signed [31:0] out_vertex_y;
  logic [16:0]        out_tex_u;
  logic [16:0]        out_tex_v;
  logic [4:0]         out_slot;
  logic [31:0]        out_bound_texture;
  logic [18:0]        out_index_count;
  logic               out_last;

  sprite_quad_batch_setup u_dut (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // ---- predictor state: mirrors the batch held inside the block ------------
  logic [31:0] white_tex;
  logic [15:0] batch_limit;
  logic [31:0] bound_handles [SLOTS];
  int          slots_used;     // next free slot
  logic [15:0] quads_in_batch;

  sprite_req_t pending_reqs [$];
  gfx_beat_t   expected_beats [$];
  int          error_count = 0;
  int          idle_cycles = 0;

  task automatic report(input string what, input longint got, input longint want);
    error_count++;
    $display("%0t mismatch %s: got %0h expected %0h", $realtime, what, got, want);
  endtask

  // Q16 sine of a quarter wave, x in Q16 covering 0..1 of the quadrant
  function automatic longint quarter_sin(input longint unsigned x);
    longint unsigned x2, x3, x5, s;
    x2 = (x * x) >> 16;
    x3 = (x2 * x) >> 16;
    x5 = (x3 * x2) >> 16;
    s  = (64'd102944 * x + 64'd4640 * x5 - 64'd42048 * x3) >> 16;
    if (s > 65536) s = 65536;
    return longint'(s);
  endfunction

  function automatic longint phase_sin(input logic [15:0] ph);
    longint unsigned x;
    longint s;
    x = {ph[13:0], 2'b00};
    s = ph[14] ? quarter_sin(65536 - x) : quarter_sin(x);
    return ph[15] ? -s : s;
  endfunction

  // position plus half-size term scaled down by 2^17, round half up, saturate
  function automatic logic [31:0] place(input longint p, input longint term);
    longint v;
    v = p + ((term + 65536) >>> 17);
    if (v > 64'sd2147483647) v = 64'sd2147483647;
    if (v < -64'sd2147483648) v = -64'sd2147483648;
    return v[31:0];
  endfunction

  function automatic logic [16:0] cap_coord(input logic [16:0] v);
    return (v > ONE_Q16) ? ONE_Q16 : v;
  endfunction

  // bindings for every slot in use, then the draw beat; empties the batch
  task automatic predict_flush();
    gfx_beat_t b;
    for (int i = 0; i < slots_used; i++) begin
      b = '{default: '0};
      b.kind  = KIND_BIND;
      b.slot  = i[4:0];
      b.bound = (i == 0) ? white_tex : bound_handles[i];
      expected_beats.push_back(b);
    end
    b = '{default: '0};
    b.kind  = KIND_DRAW;
    b.count = 19'(quads_in_batch * 6);
    expected_beats.push_back(b);
    quads_in_batch = '0;
    slots_used = 1;
  endtask

  task automatic predict_request(input sprite_req_t r);
    logic [16:0] tu [4];
    logic [16:0] tv [4];
    int          slot;
    longint      s, c, ax, ay;
    gfx_beat_t   b;
    slot = 0;
    if (r.func == FUNC_NONE) return;  // ignored entirely
    if (r.func == FUNC_FLUSH) begin
      predict_flush();
      expected_beats[$].last = 1'b1;
      return;
    end
    // automatic flush: batch full, or no slot left for a textured quad
    if (quads_in_batch >= batch_limit || (r.func == FUNC_TEX && slots_used >= SLOTS))
      predict_flush();
    if (r.func == FUNC_PLAIN) begin
      tu = '{17'd0, ONE_Q16, ONE_Q16, 17'd0};
      tv = '{17'd0, 17'd0, ONE_Q16, ONE_Q16};
    end else begin
      tu = '{cap_coord(r.ul_u), cap_coord(r.br_u), cap_coord(r.br_u), cap_coord(r.ul_u)};
      tv = '{cap_coord(r.br_v), cap_coord(r.br_v), cap_coord(r.ul_v), cap_coord(r.ul_v)};
      // slot zero belongs to the white texture and is never searched
      for (int j = 1; j < slots_used; j++) begin
        if (bound_handles[j] == r.handle) begin
          slot = j;
          break;
        end
      end
      if (slot == 0) begin
        slot = slots_used;
        bound_handles[slot] = r.handle;
        slots_used++;
      end
    end
    s = phase_sin(r.angle);
    c = phase_sin(r.angle + QUARTER_TURN);
    for (int i = 0; i < 4; i++) begin
      ax = CORNER_SX[i] * longint'(r.size_x);
      ay = CORNER_SY[i] * longint'(r.size_y);
      b = '{default: '0};
      b.kind = KIND_VERTEX;
      b.vx   = place(longint'(r.pos_x), ax * c - ay * s);
      b.vy   = place(longint'(r.pos_y), ax * s + ay * c);
      b.tu   = tu[i];
      b.tv   = tv[i];
      b.slot = slot[4:0];
      b.last = (i == 3);
      expected_beats.push_back(b);
    end
    quads_in_batch++;
  endtask

  // ---- request driver: bursts of beats with random gaps --------------------
  sprite_req_t on_bus;
  int burst_left = 0;
  int gap_left = 0;

  always @(posedge clk) begin
    if (in_valid && !in_stall) predict_request(on_bus);
    if (!in_valid || !in_stall) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (rst_n && pending_reqs.size() > 0) begin
        on_bus = pending_reqs.pop_front();
        in_func           <= on_bus.func;
        in_texture_handle <= on_bus.handle;
        in_pos_x          <= on_bus.pos_x;
        in_pos_y          <= on_bus.pos_y;
        in_size_x         <= on_bus.size_x;
        in_size_y         <= on_bus.size_y;
        in_angle          <= on_bus.angle;
        in_ul_u           <= on_bus.ul_u;
        in_ul_v           <= on_bus.ul_v;
        in_br_u           <= on_bus.br_u;
        in_br_v           <= on_bus.br_v;
        in_valid          <= 1'b1;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 12);
          // some bursts run back to back with no gap at all
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // ---- result monitor with its own stall pattern ---------------------------
  int stall_mode = 0;
  int stall_tick = 0;
  gfx_beat_t want;

  always @(posedge clk) begin
    if (out_valid && !out_stall) begin
      if (expected_beats.size() == 0) begin
        report("unexpected beat, kind", out_kind, 0);
      end else begin
        want = expected_beats.pop_front();
        if (out_kind !== want.kind) report("kind", out_kind, want.kind);
        if (out_vertex_x !== want.vx) report("vertex_x", out_vertex_x, want.vx);
        if (out_vertex_y !== want.vy) report("vertex_y", out_vertex_y, want.vy);
        if (out_tex_u !== want.tu) report("tex_u", out_tex_u, want.tu);
        if (out_tex_v !== want.tv) report("tex_v", out_tex_v, want.tv);
        if (out_slot !== want.slot) report("slot", out_slot, want.slot);
        if (out_bound_texture !== want.bound)
          report("bound_texture", out_bound_texture, want.bound);
        if (out_index_count !== want.count)
          report("index_count", out_index_count, want.count);
        if (out_last !== want.last) report("last", out_last, want.last);
      end
    end
    // pattern is re-picked at random as stall_tick advances: open, random, heavy, periodic
    stall_tick++;
    if (stall_tick % 50 == 0) stall_mode = $urandom_range(0, 3);
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= $urandom_range(0, 1);
      2: out_stall <= ($urandom_range(0, 3) != 0);
      default: out_stall <= (stall_tick % 3 == 0);
    endcase
  end

  // ---- watchdog: any accepted beat on either side resets it ----------------
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG) begin
      $display("sprite_quad_batch_setup_test: errors");
      $finish;
    end
  end

  // ---- stimulus --------------------------------------------------------------
  int unsigned handle_pool [40];

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_WHITE) white_tex = val;
    else batch_limit = val[15:0];
  endtask

  task automatic set_config(input logic [31:0] white, input logic [15:0] limit);
    write_reg(CFG_WHITE, white);
    write_reg(CFG_MAXQ, {16'd0, limit});
  endtask

  // block must be drained before the configuration may change; the bench
  // has to stay quiet for a whole pause, so a beat just handed to the bus
  // is always seen
  task automatic wait_drained();
    int quiet;
    quiet = 0;
    while (quiet < IDLE_PAUSE) begin
      @(posedge clk);
      if (pending_reqs.size() > 0 || in_valid || expected_beats.size() > 0) quiet = 0;
      else quiet++;
    end
  endtask

  function automatic sprite_req_t quad(input logic [1:0] f, input logic [31:0] h,
                                       input logic [31:0] px, input logic [31:0] py,
                                       input logic [30:0] sx, input logic [30:0] sy,
                                       input logic [15:0] a, input logic [16:0] uv);
    sprite_req_t r;
    r = '{f, h, px, py, sx, sy, a, uv, uv, uv, uv};
    return r;
  endfunction

  function automatic sprite_req_t random_req();
    sprite_req_t r;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 45) r.func = FUNC_TEX;
    else if (pick < 82) r.func = FUNC_PLAIN;
    else if (pick < 94) r.func = FUNC_FLUSH;
    else r.func = FUNC_NONE;
    // mostly a shared pool so handles repeat; sometimes a fresh one
    r.handle = ($urandom_range(0, 4) == 0) ? $urandom()
             : handle_pool[$urandom_range(0, 39)];
    r.pos_x = $urandom();
    r.pos_y = $urandom();
    if ($urandom_range(0, 2) == 0) begin
      r.size_x = 31'($urandom());
      r.size_y = 31'($urandom());
    end else begin
      r.size_x = 31'($urandom_range(0, 32'h0040_0000));
      r.size_y = 31'($urandom_range(0, 32'h0040_0000));
    end
    r.angle = 16'($urandom_range(0, 65535));
    r.ul_u = 17'($urandom_range(0, 131071));
    r.ul_v = 17'($urandom_range(0, 131071));
    r.br_u = 17'($urandom_range(0, 131071));
    r.br_v = 17'($urandom_range(0, 131071));
    return r;
  endfunction

  initial begin
    logic [31:0] white;
    logic [15:0] limits [5];
    white_tex = '0;
    batch_limit = 16'd1000;
    slots_used = 1;
    quads_in_batch = '0;
    foreach (bound_handles[i]) bound_handles[i] = '0;
    foreach (handle_pool[i]) handle_pool[i] = $urandom();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // directed: field extremes, every function, the named corner cases
    white = $urandom();
    set_config(white, 16'd3);
    pending_reqs.push_back(quad(FUNC_FLUSH, 0, 0, 0, 0, 0, 0, 0));     // empty flush
    pending_reqs.push_back(quad(FUNC_PLAIN, 0, 0, 0, 31'h10000, 31'h10000, 0, 0));
    pending_reqs.push_back(quad(FUNC_PLAIN, '1, 32'h7FFFFFFF, 32'h7FFFFFFF,
                                '1, '1, 16'd8192, '1));                // saturate high
    pending_reqs.push_back(quad(FUNC_PLAIN, 0, 32'h80000000, 32'h80000000,
                                '1, '1, 16'd40000, 0));                // saturate low
    pending_reqs.push_back(quad(FUNC_TEX, white, 32'h1234, 32'hFFFF0000,
                                31'h30000, 31'h8000, 16'd16384, 0));   // handle == white
    pending_reqs.push_back(quad(FUNC_TEX, '1, 0, 0, 31'h20000, 31'h50000,
                                16'd32768, 17'h1FFFF));                // coords capped
    pending_reqs.push_back(quad(FUNC_TEX, '1, 32'h100, 32'h200, 31'h1, 31'h1,
                                16'd49152, ONE_Q16));                  // repeated handle
    pending_reqs.push_back(quad(FUNC_NONE, '1, '1, '1, '1, '1, '1, '1));
    pending_reqs.push_back(quad(FUNC_TEX, 32'h5A5A5A5A, 32'hFFFFFFFF, 1,
                                31'h7FFF0000, 31'h12345, 16'd65535, 17'd65535));
    pending_reqs.push_back(quad(FUNC_PLAIN, 0, 0, 0, 31'h40000, 31'h40000, 16'd1, 0));
    pending_reqs.push_back(quad(FUNC_FLUSH, 0, 0, 0, 0, 0, 0, 0));
    pending_reqs.push_back(quad(FUNC_FLUSH, 0, 0, 0, 0, 0, 0, 0));
    for (int a = 0; a < 8; a++)
      pending_reqs.push_back(quad(FUNC_PLAIN, 0, 0, 0, 31'h10000, 31'h20000,
                                  16'(a * 8192 + 4096), 0));
    wait_drained();

    // random phases; limits include the extremes, zero and lowered values
    limits = '{16'd65535, 16'd1, 16'd0, 16'd40, 16'd4};
    for (int p = 0; p < 5; p++) begin
      case (p)
        0: white = '1;
        2: white = '0;
        default: white = $urandom();
      endcase
      set_config(white, limits[p]);
      if (p == 0) begin
        // run the slot table dry: 35 distinct textures, more than the 31 free slots of a batch
        for (int k = 0; k < 35; k++) begin
          sprite_req_t r;
          r = random_req();
          r.func = FUNC_TEX;
          r.handle = 32'hC000_0000 + k;
          pending_reqs.push_back(r);
        end
      end
      for (int k = 0; k < 40; k++) pending_reqs.push_back(random_req());
      wait_drained();
    end

    if (error_count == 0) begin
      $display("sprite_quad_batch_setup_test: clean");
    end else begin
      $display("sprite_quad_batch_setup_test: errors");
    end
    $finish;
  end

endmodule
